/* rtl/mtfzr_pkg.sv */
package mtfzr_pkg;

  localparam int ALPHABET_DEF   = 256;
  localparam int COUNT_BITS_DEF = 16;

  localparam int BYTE_W     = 8;
  localparam int SYM_W      = 9;
  localparam int CNT_W      = 16;
  localparam int BASE_W     = 17;
  localparam int MAP_W      = 64;
  localparam int MAP_WORDS  = 4;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 64;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_USAGE_MAP_0 = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_USAGE_MAP_1 = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_USAGE_MAP_2 = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_USAGE_MAP_3 = 3'd3;

  // commands from the controller to every cell of the list
  typedef struct packed {
    logic              clear;     // zero every entry
    logic              shift_in;  // push new_byte in at the front, all entries move back
    logic [BYTE_W-1:0] new_byte;
    logic              swap;      // swap the entry pair selected by the pointer
  } cell_ctl_t;

endpackage

/* rtl/mtfzr_cell.sv */
module mtfzr_cell #(
  parameter int INDEX = 0,
  parameter int PTR_W = 8
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  mtfzr_pkg::cell_ctl_t      ctl,
  input  logic [PTR_W-1:0]          ptr,
  input  logic [mtfzr_pkg::BYTE_W-1:0] left_val,
  input  logic [mtfzr_pkg::BYTE_W-1:0] right_val,
  output logic [mtfzr_pkg::BYTE_W-1:0] val
);
  import mtfzr_pkg::*;

  logic [BYTE_W-1:0] val_r;
  logic [BYTE_W-1:0] val_nxt;
  logic              swap_here;
  logic              swap_prev;

  // pointer p swaps entries p and p+1
  assign swap_here = ctl.swap && (ptr == PTR_W'(INDEX));
  assign swap_prev = ctl.swap && (INDEX != 0) && (ptr == PTR_W'(INDEX - 1));

  always_comb begin
    val_nxt = val_r;
    if (ctl.clear) begin
      val_nxt = '0;
    end else if (ctl.shift_in) begin
      val_nxt = left_val;
    end else if (swap_here) begin
      val_nxt = right_val;
    end else if (swap_prev) begin
      val_nxt = left_val;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      val_r <= BYTE_W'(INDEX);
    end else begin
      val_r <= val_nxt;
    end
  end

  assign val = val_r;

endmodule

/* rtl/mtfzr_ctrl.sv */
module mtfzr_ctrl #(
  parameter int ALPHABET   = 256,
  parameter int COUNT_BITS = 16,
  parameter int PTR_W      = 8
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          in_start_block,
  input  logic [mtfzr_pkg::SYM_W-1:0]   in_symbol,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [mtfzr_pkg::BYTE_W-1:0]  out_byte,
  output logic [mtfzr_pkg::CNT_W-1:0]   out_repeat_count,
  output logic                          out_bad_symbol,
  output logic                          out_run_overflow,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [mtfzr_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [mtfzr_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic [mtfzr_pkg::BYTE_W-1:0]  front_val,
  output mtfzr_pkg::cell_ctl_t          ctl,
  output logic [PTR_W-1:0]              ptr
);
  import mtfzr_pkg::*;

  localparam int ASZ_W = $clog2(ALPHABET + 1);
  localparam int CNT_MAX_I = (COUNT_BITS >= 16) ? 65535 : ((1 << COUNT_BITS) - 1);
  localparam logic [BASE_W:0]   CNT_MAX  = (BASE_W + 1)'(CNT_MAX_I);
  localparam logic [BASE_W-1:0] BASE_SAT = '1;
  localparam logic [BASE_W-1:0] BASE_ONE = BASE_W'(1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SWAP,
    ST_FIN,
    ST_BUILD
  } state_t;

  state_t             state_r, state_nxt;
  logic [MAP_W-1:0]   umap_r [MAP_WORDS];
  logic [MAP_W-1:0]   umap_nxt [MAP_WORDS];
  logic [ALPHABET-1:0] map_sh_r, map_sh_nxt;
  logic [PTR_W-1:0]   ptr_r, ptr_nxt;
  logic [BASE_W-1:0]  base_r, base_nxt;
  logic [ASZ_W-1:0]   asz_r, asz_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [BYTE_W-1:0]  out_byte_r, out_byte_nxt;
  logic [CNT_W-1:0]   out_cnt_r, out_cnt_nxt;
  logic               out_bad_r, out_bad_nxt;
  logic               out_ovf_r, out_ovf_nxt;

  logic               slot_free;
  logic               in_fire;
  logic [SYM_W-1:0]   idx;
  logic               idx_bad;
  logic [BASE_W:0]    run_cnt;
  logic               run_ovf;
  logic [MAP_WORDS*MAP_W-1:0] map_all;

  assign slot_free = !out_valid_r || out_ready;
  assign in_ready  = (state_r == ST_IDLE) && slot_free;
  assign in_fire   = in_valid && in_ready;
  assign cfg_ready = 1'b1;

  assign idx     = in_symbol - SYM_W'(1);
  assign idx_bad = ({{(SYM_W + 1 - ASZ_W){1'b0}}, asz_r} <= {1'b0, idx});
  assign run_cnt = {1'b0, base_r} << in_symbol[0];
  assign run_ovf = (base_r == BASE_SAT) || (run_cnt > CNT_MAX);
  assign map_all = {umap_r[3], umap_r[2], umap_r[1], umap_r[0]};

  // cell commands
  assign ctl.clear    = in_fire && in_start_block;
  assign ctl.shift_in = (state_r == ST_BUILD) && map_sh_r[ALPHABET-1];
  assign ctl.new_byte = BYTE_W'(ptr_r);
  assign ctl.swap     = (state_r == ST_SWAP);
  assign ptr          = ptr_r;

  always_comb begin
    state_nxt     = state_r;
    umap_nxt      = umap_r;
    map_sh_nxt    = map_sh_r;
    ptr_nxt       = ptr_r;
    base_nxt      = base_r;
    asz_nxt       = asz_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_byte_nxt  = out_byte_r;
    out_cnt_nxt   = out_cnt_r;
    out_bad_nxt   = out_bad_r;
    out_ovf_nxt   = out_ovf_r;

    if (cfg_valid) begin
      case (cfg_index)
        CFG_USAGE_MAP_0: umap_nxt[0] = cfg_data;
        CFG_USAGE_MAP_1: umap_nxt[1] = cfg_data;
        CFG_USAGE_MAP_2: umap_nxt[2] = cfg_data;
        CFG_USAGE_MAP_3: umap_nxt[3] = cfg_data;
        default: ;
      endcase
    end

    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          if (in_start_block) begin
            map_sh_nxt = map_all[ALPHABET-1:0];
            ptr_nxt    = PTR_W'(ALPHABET - 1);
            asz_nxt    = '0;
            base_nxt   = BASE_ONE;
            state_nxt  = ST_BUILD;
          end else if (in_symbol < SYM_W'(2)) begin
            out_valid_nxt = 1'b1;
            out_byte_nxt  = '0;
            out_cnt_nxt   = '0;
            out_bad_nxt   = 1'b0;
            out_ovf_nxt   = 1'b0;
            if (asz_r == '0) begin
              out_bad_nxt = 1'b1;
            end else begin
              out_byte_nxt = front_val;
              out_ovf_nxt  = run_ovf;
              out_cnt_nxt  = run_ovf ? CNT_MAX[CNT_W-1:0] : run_cnt[CNT_W-1:0];
            end
            if (base_r[BASE_W-1]) begin
              base_nxt = BASE_SAT;
            end else begin
              base_nxt = {base_r[BASE_W-2:0], 1'b0};
            end
          end else begin
            base_nxt = BASE_ONE;
            if (idx_bad) begin
              out_valid_nxt = 1'b1;
              out_byte_nxt  = '0;
              out_cnt_nxt   = '0;
              out_bad_nxt   = 1'b1;
              out_ovf_nxt   = 1'b0;
            end else begin
              ptr_nxt   = PTR_W'(idx - SYM_W'(1));
              state_nxt = ST_SWAP;
            end
          end
        end
      end
      ST_SWAP: begin
        if (ptr_r == '0) begin
          state_nxt = ST_FIN;
        end else begin
          ptr_nxt = ptr_r - PTR_W'(1);
        end
      end
      ST_FIN: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          out_byte_nxt  = front_val;
          out_cnt_nxt   = CNT_W'(1);
          out_bad_nxt   = 1'b0;
          out_ovf_nxt   = 1'b0;
          state_nxt     = ST_IDLE;
        end
      end
      ST_BUILD: begin
        // byte values scanned from the top down, used ones pushed in at the front
        if (map_sh_r[ALPHABET-1]) begin
          asz_nxt = asz_r + ASZ_W'(1);
        end
        map_sh_nxt = map_sh_r << 1;
        if (ptr_r == '0) begin
          state_nxt = ST_IDLE;
        end else begin
          ptr_nxt = ptr_r - PTR_W'(1);
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      umap_r      <= '{default: '1};
      ptr_r       <= '0;
      base_r      <= BASE_ONE;
      asz_r       <= ASZ_W'(ALPHABET);
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      umap_r      <= umap_nxt;
      ptr_r       <= ptr_nxt;
      base_r      <= base_nxt;
      asz_r       <= asz_nxt;
      out_valid_r <= out_valid_nxt;
    end
    map_sh_r   <= map_sh_nxt;
    out_byte_r <= out_byte_nxt;
    out_cnt_r  <= out_cnt_nxt;
    out_bad_r  <= out_bad_nxt;
    out_ovf_r  <= out_ovf_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_byte         = out_byte_r;
  assign out_repeat_count = out_cnt_r;
  assign out_bad_symbol   = out_bad_r;
  assign out_run_overflow = out_ovf_r;

  a_busy_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_IDLE) |-> !in_ready)
    else $error("input taken while list is busy");

  a_base_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    base_r != '0)
    else $error("run base reached zero");

  a_alphabet_bound: assert property (@(posedge clk) disable iff (!rst_n)
    asz_r <= ASZ_W'(ALPHABET))
    else $error("alphabet size beyond cell count");

  a_swap_continues: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SWAP && ptr_r != '0) |=> (state_r == ST_SWAP && ptr_r == $past(ptr_r) - PTR_W'(1)))
    else $error("swap pass cut short");

  a_bad_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_bad_r) |-> (out_cnt_r == '0 && !out_ovf_r && out_byte_r == '0))
    else $error("bad symbol result carries data");

endmodule

/* rtl/mtf_zero_run_decoder_unit.sv */
// move-to-front decoder with bijective base-2 zero-run expansion. each input item
// is one entropy-decoded symbol: start_block rebuilds the list from the usage map
// (used bytes ascending, no result), symbols 0 and 1 are run digits that give the
// list front with a repeat count of base << digit, and symbol k >= 2 takes list
// entry k-1, moves it to the front and gives it once. the list is a row of
// ALPHABET cells; a literal bubbles its byte toward the front by neighbor swaps,
// one cell per cycle. a block start shifts the usage map through one byte value per
// cycle. configuration is the four 64-bit usage map words (cfg_index 0..3, other
// indexes ignored), to be written by the user only while idle; the block itself
// does not enforce this. reset sets them to all ones and the list to identity.
module mtf_zero_run_decoder_unit #(
  parameter int ALPHABET   = mtfzr_pkg::ALPHABET_DEF,
  parameter int COUNT_BITS = mtfzr_pkg::COUNT_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  // symbol items
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic                             in_start_block,
  input  logic [mtfzr_pkg::SYM_W-1:0]      in_symbol,
  // result items
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [mtfzr_pkg::BYTE_W-1:0]     out_byte,
  output logic [mtfzr_pkg::CNT_W-1:0]      out_repeat_count,
  output logic                             out_bad_symbol,
  output logic                             out_run_overflow,
  // usage map writes
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [mtfzr_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [mtfzr_pkg::CFG_DATA_W-1:0] cfg_data
);
  import mtfzr_pkg::*;

  // pointer selects a swap pair during literals and the byte value during rebuild
  localparam int PTR_W = $clog2(ALPHABET);

  cell_ctl_t         ctl;
  logic [PTR_W-1:0]  ptr;
  logic [BYTE_W-1:0] cell_val [ALPHABET];

  mtfzr_ctrl #(
    .ALPHABET  (ALPHABET),
    .COUNT_BITS(COUNT_BITS),
    .PTR_W     (PTR_W)
  ) u_ctrl (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_start_block  (in_start_block),
    .in_symbol       (in_symbol),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_byte        (out_byte),
    .out_repeat_count(out_repeat_count),
    .out_bad_symbol  (out_bad_symbol),
    .out_run_overflow(out_run_overflow),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .front_val       (cell_val[0]),
    .ctl             (ctl),
    .ptr             (ptr)
  );

  // the list: cell 0 is the front, new bytes enter there during rebuild
  for (genvar j = 0; j < ALPHABET; j++) begin : g_cell
    logic [BYTE_W-1:0] left_val;
    logic [BYTE_W-1:0] right_val;

    if (j == 0) begin : g_first
      assign left_val = ctl.new_byte;
    end else begin : g_mid_l
      assign left_val = cell_val[j-1];
    end

    if (j == ALPHABET - 1) begin : g_last
      assign right_val = '0;
    end else begin : g_mid_r
      assign right_val = cell_val[j+1];
    end

    mtfzr_cell #(
      .INDEX(j),
      .PTR_W(PTR_W)
    ) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .ctl      (ctl),
      .ptr      (ptr),
      .left_val (left_val),
      .right_val(right_val),
      .val      (cell_val[j])
    );
  end

endmodule
